// File: design/tsps_pkg.sv
// Package with widths, defaults and sequencer types for the totient square prefix sum block.
package tsps_pkg;

    localparam int NUM_W      = 23;
    localparam int SUM_W      = 64;
    localparam int SQ_W       = 2 * NUM_W;
    localparam int P_W        = 13;
    localparam int P2_W       = 25;
    localparam int DIV_W      = NUM_W + 1;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;
    localparam int DEFAULT_MAX_N = 8388607;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL,
        ST_SQUARE,
        ST_ACCUM
    } t_state;

    typedef enum logic [1:0] {
        DM_REST,
        DM_RES,
        DM_FINAL
    } t_dmode;

endpackage

// File: design/totient_square_prefix_sum.sv
// Totient by trial division on a shared two-bit divider, with a saturating sum of squares.
// Each trial candidate (2, then odd numbers while p*p fits the rest) runs check, divide and
// evaluate; each exact division divides again, each prime factor divides the totient, and a
// closing check hands a leftover prime factor one more division before square and accumulate.
// One transfer at a time, taken again in the cycle after the result is registered.
// Synchronous active-low reset clears state, output valid and sum.
module totient_square_prefix_sum #(
    parameter int MAX_N = tsps_pkg::DEFAULT_MAX_N
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: number [22:0], zero fill [23].
    input  logic [tsps_pkg::IN_DATA_W-1:0]      s_tdata,
    // Fields from bit 0: clear_sum.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: totient [22:0], running_sum [86:23], zero fill [87].
    output logic [tsps_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Fields from bit 0: sum_saturated.
    output logic                                m_tuser
);

    localparam int NW = tsps_pkg::NUM_W;
    localparam int SW = tsps_pkg::SUM_W;
    localparam int QW = tsps_pkg::SQ_W;
    localparam int PW = tsps_pkg::P_W;
    localparam int P2W = tsps_pkg::P2_W;
    localparam int DW = tsps_pkg::DIV_W;
    localparam int CW = tsps_pkg::CNT_W;
    localparam int NW1 = NW + 1;
    localparam logic [NW:0] MAX_N_V = NW1'(MAX_N);

    tsps_pkg::t_state r_state, n_state;
    tsps_pkg::t_dmode r_dmode, n_dmode;

    logic [NW-1:0]  r_rest, n_rest;
    logic [NW-1:0]  r_res, n_res;
    logic [PW-1:0]  r_p, n_p;
    logic [P2W-1:0] r_p2, n_p2;
    logic           r_found, n_found;
    logic           r_clear, n_clear;
    logic [NW-1:0]  r_rem, n_rem;
    logic [DW-1:0]  r_quo, n_quo;
    logic [NW-1:0]  r_dvs, n_dvs;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [QW-1:0]  r_sq, n_sq;
    logic [SW-1:0]  r_sum, n_sum;
    logic           r_mvalid, n_mvalid;
    logic [NW-1:0]  r_mtot, n_mtot;
    logic [SW-1:0]  r_msum, n_msum;

    logic [NW:0]    num_ext;
    logic [NW-1:0]  num_clamped;
    logic [NW:0]    t1, t2;
    logic           ge1, ge2;
    logic [NW-1:0]  rem1, rem2;
    logic [DW-1:0]  quo1, quo2;
    logic [PW-1:0]  p_adv;
    logic [P2W-1:0] p2_adv;
    logic [SW-1:0]  sum_base;
    logic [SW:0]    sum_add;

    assign s_tready = (r_state == tsps_pkg::ST_IDLE);
    assign m_tvalid = r_mvalid;
    assign m_tdata  = {1'b0, r_msum, r_mtot};
    assign m_tuser  = (r_msum == {SW{1'b1}});

    always_comb begin
        num_ext     = {1'b0, s_tdata[NW-1:0]};
        num_clamped = (num_ext > MAX_N_V) ? MAX_N_V[NW-1:0] : s_tdata[NW-1:0];

        t1   = {r_rem, r_quo[DW-1]};
        ge1  = (t1 >= {1'b0, r_dvs});
        rem1 = ge1 ? NW'(t1 - {1'b0, r_dvs}) : t1[NW-1:0];
        quo1 = {r_quo[DW-2:0], ge1};
        t2   = {rem1, quo1[DW-1]};
        ge2  = (t2 >= {1'b0, r_dvs});
        rem2 = ge2 ? NW'(t2 - {1'b0, r_dvs}) : t2[NW-1:0];
        quo2 = {quo1[DW-2:0], ge2};

        if (r_p == PW'(2)) begin
            p_adv  = PW'(3);
            p2_adv = r_p2 + P2W'(5);
        end else begin
            p_adv  = r_p + PW'(2);
            p2_adv = r_p2 + P2W'({r_p, 2'b00}) + P2W'(4);
        end

        sum_base = r_clear ? '0 : r_sum;
        sum_add  = {1'b0, sum_base} + (SW + 1)'(r_sq);
    end

    always_comb begin
        n_state  = r_state;
        n_dmode  = r_dmode;
        n_rest   = r_rest;
        n_res    = r_res;
        n_p      = r_p;
        n_p2     = r_p2;
        n_found  = r_found;
        n_clear  = r_clear;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_cnt    = r_cnt;
        n_sq     = r_sq;
        n_sum    = r_sum;
        n_mvalid = r_mvalid;
        n_mtot   = r_mtot;
        n_msum   = r_msum;

        if (r_mvalid && m_tready) begin
            n_mvalid = 1'b0;
        end

        case (r_state)
            tsps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_rest  = num_clamped;
                    n_res   = num_clamped;
                    n_clear = s_tuser;
                    n_p     = PW'(2);
                    n_p2    = P2W'(4);
                    n_state = tsps_pkg::ST_CHECK;
                end
            end
            tsps_pkg::ST_CHECK: begin
                n_rem = '0;
                n_cnt = '0;
                if (r_p2 <= P2W'(r_rest)) begin
                    n_quo   = DW'(r_rest);
                    n_dvs   = NW'(r_p);
                    n_dmode = tsps_pkg::DM_REST;
                    n_found = 1'b0;
                    n_state = tsps_pkg::ST_DIV;
                end else if (r_rest > NW'(1)) begin
                    n_quo   = DW'(r_res);
                    n_dvs   = r_rest;
                    n_dmode = tsps_pkg::DM_FINAL;
                    n_state = tsps_pkg::ST_DIV;
                end else begin
                    n_state = tsps_pkg::ST_SQUARE;
                end
            end
            tsps_pkg::ST_DIV: begin
                n_rem = rem2;
                n_quo = quo2;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(tsps_pkg::DIV_STEPS - 1)) begin
                    n_state = tsps_pkg::ST_EVAL;
                end
            end
            tsps_pkg::ST_EVAL: begin
                n_cnt = '0;
                case (r_dmode)
                    tsps_pkg::DM_REST: begin
                        n_rem = '0;
                        if (r_rem == '0) begin
                            n_rest  = r_quo[NW-1:0];
                            n_quo   = r_quo;
                            n_found = 1'b1;
                            n_state = tsps_pkg::ST_DIV;
                        end else if (r_found) begin
                            n_quo   = DW'(r_res);
                            n_dmode = tsps_pkg::DM_RES;
                            n_state = tsps_pkg::ST_DIV;
                        end else begin
                            n_p     = p_adv;
                            n_p2    = p2_adv;
                            n_state = tsps_pkg::ST_CHECK;
                        end
                    end
                    tsps_pkg::DM_RES: begin
                        n_res   = r_res - r_quo[NW-1:0];
                        n_found = 1'b0;
                        n_p     = p_adv;
                        n_p2    = p2_adv;
                        n_state = tsps_pkg::ST_CHECK;
                    end
                    default: begin
                        n_res   = r_res - r_quo[NW-1:0];
                        n_state = tsps_pkg::ST_SQUARE;
                    end
                endcase
            end
            tsps_pkg::ST_SQUARE: begin
                n_sq    = QW'(r_res) * QW'(r_res);
                n_state = tsps_pkg::ST_ACCUM;
            end
            tsps_pkg::ST_ACCUM: begin
                if (!r_mvalid || m_tready) begin
                    n_sum    = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
                    n_msum   = n_sum;
                    n_mtot   = r_res;
                    n_mvalid = 1'b1;
                    n_state  = tsps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tsps_pkg::ST_IDLE;
            r_mvalid <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmode <= n_dmode;
        r_rest  <= n_rest;
        r_res   <= n_res;
        r_p     <= n_p;
        r_p2    <= n_p2;
        r_found <= n_found;
        r_clear <= n_clear;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_cnt   <= n_cnt;
        r_sq    <= n_sq;
        r_mtot  <= n_mtot;
        r_msum  <= n_msum;
    end

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsps_pkg::ST_DIV) |-> (r_dvs != '0))
        else $error("divider started with zero divisor");

    // The partial remainder of the restoring divider stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsps_pkg::ST_DIV) |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

    // The step counter never passes the last divider step.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsps_pkg::ST_DIV) |-> (r_cnt < CW'(tsps_pkg::DIV_STEPS)))
        else $error("divider step counter overrun");

    // An accepted transfer always starts the sequencer.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == tsps_pkg::ST_CHECK))
        else $error("sequencer did not start after input transfer");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsps_pkg::ST_ACCUM && r_mvalid && !m_tready)
        |=> (r_state == tsps_pkg::ST_ACCUM))
        else $error("result lost while output stalled");

endmodule

// File: test/totient_square_prefix_sum_test.sv
// Self-checking testbench for the totient and saturating sum of squared totients stream block.
module totient_square_prefix_sum_test;

    localparam int NUM_W         = tsps_pkg::NUM_W;
    localparam int SUM_W         = tsps_pkg::SUM_W;
    localparam int IN_DATA_W     = tsps_pkg::IN_DATA_W;
    localparam int OUT_DATA_W    = tsps_pkg::OUT_DATA_W;
    localparam int DEFAULT_MAX_N = tsps_pkg::DEFAULT_MAX_N;

    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int RANDOM_ITEMS  = 290;
    localparam int DIRECTED_ROWS = 18;
    localparam int DRAIN_CYCLES  = 100;
    localparam logic [NUM_W-1:0] MAX_NUMBER  = NUM_W'(DEFAULT_MAX_N);
    localparam logic [SUM_W-1:0] SUM_CEILING = '1;

    typedef struct packed {
        logic [NUM_W-1:0] phi;
        logic [SUM_W-1:0] total;
        logic             saturated;
    } t_totient_result;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             clear;
        logic             typed;
        logic [NUM_W-1:0] phi;
        logic [SUM_W-1:0] total;
    } t_stim_row;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Fields from bit 0: number [22:0], zero fill [23].
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // Fields from bit 0: clear_sum.
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // Fields from bit 0: totient [22:0], running_sum [86:23], zero fill [87].
    logic [OUT_DATA_W-1:0] m_tdata;
    // Fields from bit 0: sum_saturated.
    logic                  m_tuser;

    logic [SUM_W-1:0] running_total = '0;
    t_totient_result  result_queue[$];
    logic [NUM_W-1:0] largest_number = '0;
    logic             calm = 1'b0;
    int               stall_left = 0;
    int               cycle_count = 0;
    int               error_count = 0;
    int               checked_count = 0;
    int               sent_count = 0;
    int               clear_count = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{23'd2,       1'b0, 1'b1, 23'd1,       64'd1},
        '{23'd3,       1'b0, 1'b1, 23'd2,       64'd5},
        '{23'd0,       1'b0, 1'b1, 23'd0,       64'd5},
        '{23'd1,       1'b0, 1'b1, 23'd1,       64'd6},
        '{23'd4,       1'b1, 1'b1, 23'd2,       64'd4},
        '{23'd8388593, 1'b1, 1'b1, 23'd8388592, 64'd70368475742464},
        '{23'd8388607, 1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd4194304, 1'b1, 1'b1, 23'd2097152, 64'd4398046511104},
        '{23'd510510,  1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd8334769, 1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd6,       1'b1, 1'b1, 23'd2,       64'd4},
        '{23'd8388606, 1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd7,       1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd5592405, 1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd2796202, 1'b1, 1'b0, 23'd0,       64'd0},
        '{23'd65536,   1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd9,       1'b0, 1'b0, 23'd0,       64'd0},
        '{23'd4096,    1'b0, 1'b0, 23'd0,       64'd0}
    };

    totient_square_prefix_sum #(
        .MAX_N(DEFAULT_MAX_N)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [NUM_W-1:0] phi_of(input logic [NUM_W-1:0] n);
        longint unsigned rest;
        longint unsigned acc;
        longint unsigned p;
        if (n == '0) begin
            return '0;
        end
        rest = n;
        acc  = n;
        for (p = 2; p * p <= rest; p++) begin
            if (rest % p == 0) begin
                while (rest % p == 0) begin
                    rest = rest / p;
                end
                acc = acc - acc / p;
            end
        end
        if (rest > 1) begin
            acc = acc - acc / rest;
        end
        return acc[NUM_W-1:0];
    endfunction

    function automatic t_totient_result predict_totient(input logic [NUM_W-1:0] number,
                                                        input logic clear);
        t_totient_result  r;
        logic [NUM_W-1:0] n;
        logic [SUM_W-1:0] square;
        logic [SUM_W:0]   grown;
        n      = (number > MAX_NUMBER) ? MAX_NUMBER : number;
        r.phi  = phi_of(n);
        square = SUM_W'(r.phi) * SUM_W'(r.phi);
        if (clear) begin
            running_total = '0;
        end
        grown         = {1'b0, running_total} + {1'b0, square};
        running_total = grown[SUM_W] ? SUM_CEILING : grown[SUM_W-1:0];
        r.total       = running_total;
        r.saturated   = (running_total == SUM_CEILING);
        return r;
    endfunction

    task automatic send_number(input logic [NUM_W-1:0] number, input logic clear,
                               input logic typed, input t_totient_result typed_result);
        t_totient_result predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, number};
        s_tuser  <= clear;
        do @(posedge i_clk); while (!s_tready);
        predicted = predict_totient(number, clear);
        result_queue.push_back(typed ? typed_result : predicted);
        sent_count++;
        if (clear) begin
            clear_count++;
        end
        if (number > largest_number) begin
            largest_number = number;
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && i_rst_n && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_totient_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (result_queue.size() == 0) begin
                $error("unexpected transfer: totient %0d, running_sum %0d",
                       m_tdata[NUM_W-1:0], m_tdata[NUM_W+SUM_W-1:NUM_W]);
                error_count++;
            end else begin
                want = result_queue.pop_front();
                checked_count++;
                if (m_tdata[NUM_W-1:0] !== want.phi) begin
                    $error("totient: expected %0d, actual %0d", want.phi, m_tdata[NUM_W-1:0]);
                    error_count++;
                end
                if (m_tdata[NUM_W+SUM_W-1:NUM_W] !== want.total) begin
                    $error("running_sum: expected %0d, actual %0d", want.total,
                           m_tdata[NUM_W+SUM_W-1:NUM_W]);
                    error_count++;
                end
                if (m_tuser !== want.saturated) begin
                    $error("sum_saturated: expected %0d, actual %0d", want.saturated, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("totient_square_prefix_sum verification failed");
            $finish;
        end
    end

    initial begin
        t_totient_result  typed_result;
        logic [NUM_W-1:0] number;
        int               width_pick;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            typed_result.phi       = directed_rows[i].phi;
            typed_result.total     = directed_rows[i].total;
            typed_result.saturated = 1'b0;
            send_number(directed_rows[i].number, directed_rows[i].clear,
                        directed_rows[i].typed, typed_result);
        end

        // Hold the input side until the block has handed back every result.
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (result_queue.size() != 0);

        // Mostly short numbers keep trial division quick; a few span the full width.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 120 && i < 150) || (i >= RANDOM_ITEMS - 40);
            width_pick = $urandom_range(0, 99);
            if (width_pick < 5) begin
                number = NUM_W'($urandom_range(2, DEFAULT_MAX_N));
            end else if (width_pick < 30) begin
                number = NUM_W'($urandom_range(2, 65535));
            end else begin
                number = NUM_W'($urandom_range(2, 4095));
            end
            send_number(number, $urandom_range(0, 9) == 0, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d number transfers (%0d directed), %0d of them restarting the sum.",
                 sent_count, DIRECTED_ROWS, clear_count);
        $display("Compared %0d result transfers; largest number sent was %0d.",
                 checked_count, largest_number);
        if (error_count == 0) begin
            $display("totient_square_prefix_sum verification clean");
        end else begin
            $display("totient_square_prefix_sum verification failed");
        end
        $finish;
    end

endmodule
